>>> hw/rtl/mfsc_pkg.sv
// ----------------------------------------------------------------------------
// Font slot cache package
// Shared constants, types and the slot base function of the move-to-front
// font slot cache.
// ----------------------------------------------------------------------------
package mfsc_pkg;

   // Number of font slots held by the cache.
   localparam int ENTRIES    = 10;

   localparam int WIN_W      = 8;
   localparam int SIZE_W     = 8;
   localparam int FAMILY_W   = 2;
   localparam int KEY_W      = WIN_W + 2 + SIZE_W + FAMILY_W;
   localparam int BASE_W     = 12;
   localparam int REMOVED_W  = 4;

   // Slot position, entry count and slot number k of a base 1000 + 260 * k.
   localparam int IDX_W      = $clog2(ENTRIES);
   localparam int CNT_W      = $clog2(ENTRIES + 1);
   localparam int SLOT_W     = $clog2(ENTRIES + 1);

   localparam int BASE_START = 1000;
   localparam int BASE_STEP  = 260;

   // Request operation codes.
   localparam logic OP_LOOKUP  = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_APPLY,
      ST_RELEASE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic search;
      logic apply;
      logic rel_step;
      logic rel_finish;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic             is_release;
      logic             win_found;
      logic             out_free;
      logic [CNT_W-1:0] count;
   } status_type;

   // Display list base of slot number k, wrapped to the base width.
   function automatic logic [BASE_W-1:0] slot_base(input logic [SLOT_W-1:0] k);
      logic [31:0] full_sum;
      full_sum = 32'(BASE_START) + 32'(BASE_STEP) * 32'(k);
      return full_sum[BASE_W-1:0];
   endfunction

endpackage

>>> hw/rtl/mfsc_req_if.sv
// ----------------------------------------------------------------------------
// Font slot cache request channel
// Valid/ready channel carrying one lookup or release request per beat.
// ----------------------------------------------------------------------------
interface mfsc_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 op;
   logic [mfsc_pkg::WIN_W-1:0]           window_id;
   logic                                 italic;
   logic                                 bold;
   logic [mfsc_pkg::SIZE_W-1:0]          font_size;
   logic [mfsc_pkg::FAMILY_W-1:0]        font_family;

   modport source (
      output valid, op, window_id, italic, bold, font_size, font_family,
      input  ready
   );

   modport sink (
      input  valid, op, window_id, italic, bold, font_size, font_family,
      output ready
   );
endinterface

>>> hw/rtl/mfsc_rsp_if.sv
// ----------------------------------------------------------------------------
// Font slot cache response channel
// Valid/ready channel carrying one result per beat.
// ----------------------------------------------------------------------------
interface mfsc_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [mfsc_pkg::BASE_W-1:0]          list_base;
   logic                                 hit;
   logic                                 evicted;
   logic [mfsc_pkg::BASE_W-1:0]          evicted_base;
   logic [mfsc_pkg::REMOVED_W-1:0]       removed_count;

   modport source (
      output valid, list_base, hit, evicted, evicted_base, removed_count,
      input  ready
   );

   modport sink (
      input  valid, list_base, hit, evicted, evicted_base, removed_count,
      output ready
   );
endinterface

>>> hw/rtl/mfsc_ctrl.sv
// ----------------------------------------------------------------------------
// Font slot cache controller
// Sequences capture, search, update and release steps of the datapath.
// ----------------------------------------------------------------------------
module mfsc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  mfsc_pkg::status_type   status,
   output mfsc_pkg::cmd_type      cmd
);

   mfsc_pkg::state_type state_ff;
   mfsc_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mfsc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         mfsc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = mfsc_pkg::ST_SEARCH;
            end
         end
         mfsc_pkg::ST_SEARCH: begin
            if (status.is_release) begin
               state_in = mfsc_pkg::ST_RELEASE;
            end else begin
               cmd.search = 1'b1;
               state_in   = mfsc_pkg::ST_APPLY;
            end
         end
         mfsc_pkg::ST_APPLY: begin
            if (status.out_free) begin
               cmd.apply = 1'b1;
               state_in  = mfsc_pkg::ST_IDLE;
            end
         end
         mfsc_pkg::ST_RELEASE: begin
            // Remove one matching entry per cycle until none is left.
            if (status.win_found) begin
               cmd.rel_step = 1'b1;
            end else if (status.out_free) begin
               cmd.rel_finish = 1'b1;
               state_in       = mfsc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mfsc_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

>>> hw/rtl/mfsc_datapath.sv
// ----------------------------------------------------------------------------
// Font slot cache datapath
// Slot registers in recency order, match logic, free slot search and the
// response register.
// ----------------------------------------------------------------------------
module mfsc_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mfsc_pkg::cmd_type                    cmd,
   output mfsc_pkg::status_type                 status,
   input  logic                                 req_op,
   input  logic [mfsc_pkg::WIN_W-1:0]           req_window_id,
   input  logic                                 req_italic,
   input  logic                                 req_bold,
   input  logic [mfsc_pkg::SIZE_W-1:0]          req_font_size,
   input  logic [mfsc_pkg::FAMILY_W-1:0]        req_font_family,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output logic [mfsc_pkg::BASE_W-1:0]          rsp_list_base,
   output logic                                 rsp_hit,
   output logic                                 rsp_evicted,
   output logic [mfsc_pkg::BASE_W-1:0]          rsp_evicted_base,
   output logic [mfsc_pkg::REMOVED_W-1:0]       rsp_removed_count
);

   localparam int E = mfsc_pkg::ENTRIES;

   // Request registers.
   logic                             op_ff, op_in;
   logic [mfsc_pkg::KEY_W-1:0]       key_ff, key_in;

   // Slots, position 0 being the most recently used.
   logic [mfsc_pkg::KEY_W-1:0]       slot_key_ff [E];
   logic [mfsc_pkg::KEY_W-1:0]       slot_key_in [E];
   logic [mfsc_pkg::SLOT_W-1:0]      slot_k_ff   [E];
   logic [mfsc_pkg::SLOT_W-1:0]      slot_k_in   [E];
   logic [mfsc_pkg::CNT_W-1:0]       count_ff, count_in;

   // Search results.
   logic                             hit_ff, hit_in;
   logic [mfsc_pkg::IDX_W-1:0]       pos_ff, pos_in;
   logic [mfsc_pkg::SLOT_W-1:0]      free_k_ff, free_k_in;
   logic [mfsc_pkg::REMOVED_W-1:0]   removed_ff, removed_in;

   // Response register.
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [mfsc_pkg::BASE_W-1:0]      rsp_base_ff, rsp_base_in;
   logic                             rsp_hit_ff, rsp_hit_in;
   logic                             rsp_ev_ff, rsp_ev_in;
   logic [mfsc_pkg::BASE_W-1:0]      rsp_evb_ff, rsp_evb_in;
   logic [mfsc_pkg::REMOVED_W-1:0]   rsp_rem_ff, rsp_rem_in;

   // Combinational search.
   logic                             any_hit;
   logic [mfsc_pkg::IDX_W-1:0]       hit_pos;
   logic                             any_win;
   logic [mfsc_pkg::IDX_W-1:0]       win_pos;
   logic [E:1]                       k_used;
   logic [mfsc_pkg::SLOT_W-1:0]      free_k;
   logic                             full;
   logic [mfsc_pkg::IDX_W-1:0]       apply_pos;
   logic [mfsc_pkg::SLOT_W-1:0]      new_k;
   logic                             out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign full     = (count_ff == mfsc_pkg::CNT_W'(E));

   // First held entry matching the full key, and the first of the window.
   always_comb begin
      any_hit = 1'b0;
      hit_pos = '0;
      any_win = 1'b0;
      win_pos = '0;
      for (int i = E - 1; i >= 0; i--) begin
         if (mfsc_pkg::CNT_W'(i) < count_ff) begin
            if (slot_key_ff[i] == key_ff) begin
               any_hit = 1'b1;
               hit_pos = mfsc_pkg::IDX_W'(i);
            end
            if (slot_key_ff[i][mfsc_pkg::KEY_W-1 -: mfsc_pkg::WIN_W] ==
                key_ff[mfsc_pkg::KEY_W-1 -: mfsc_pkg::WIN_W]) begin
               any_win = 1'b1;
               win_pos = mfsc_pkg::IDX_W'(i);
            end
         end
      end
   end

   // Smallest slot number not used by a held entry.
   always_comb begin
      k_used = '0;
      free_k = mfsc_pkg::SLOT_W'(1);
      for (int kk = 1; kk <= E; kk++) begin
         for (int i = 0; i < E; i++) begin
            if ((mfsc_pkg::CNT_W'(i) < count_ff) &&
                (slot_k_ff[i] == mfsc_pkg::SLOT_W'(kk))) begin
               k_used[kk] = 1'b1;
            end
         end
      end
      for (int kk = E; kk >= 1; kk--) begin
         if (!k_used[kk]) begin
            free_k = mfsc_pkg::SLOT_W'(kk);
         end
      end
   end

   always_comb begin
      if (hit_ff) begin
         apply_pos = pos_ff;
         new_k     = slot_k_ff[pos_ff];
      end else if (full) begin
         apply_pos = mfsc_pkg::IDX_W'(E - 1);
         new_k     = slot_k_ff[E-1];
      end else begin
         apply_pos = count_ff[mfsc_pkg::IDX_W-1:0];
         new_k     = free_k_ff;
      end
   end

   always_comb begin
      op_in        = op_ff;
      key_in       = key_ff;
      count_in     = count_ff;
      hit_in       = hit_ff;
      pos_in       = pos_ff;
      free_k_in    = free_k_ff;
      removed_in   = removed_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_base_in  = rsp_base_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_ev_in    = rsp_ev_ff;
      rsp_evb_in   = rsp_evb_ff;
      rsp_rem_in   = rsp_rem_ff;
      for (int i = 0; i < E; i++) begin
         slot_key_in[i] = slot_key_ff[i];
         slot_k_in[i]   = slot_k_ff[i];
      end

      if (cmd.capture) begin
         op_in      = req_op;
         key_in     = {req_window_id, req_italic, req_bold, req_font_size,
                       req_font_family};
         removed_in = '0;
      end

      if (cmd.search) begin
         hit_in    = any_hit;
         pos_in    = hit_pos;
         free_k_in = free_k;
      end

      if (cmd.apply) begin
         // Move to front: entries ahead of the chosen position slide back.
         for (int i = 1; i < E; i++) begin
            if (mfsc_pkg::IDX_W'(i) <= apply_pos) begin
               slot_key_in[i] = slot_key_ff[i-1];
               slot_k_in[i]   = slot_k_ff[i-1];
            end
         end
         slot_key_in[0] = key_ff;
         slot_k_in[0]   = new_k;
         if (!hit_ff && !full) begin
            count_in = count_ff + mfsc_pkg::CNT_W'(1);
         end
         rsp_valid_in = 1'b1;
         rsp_base_in  = mfsc_pkg::slot_base(new_k);
         rsp_hit_in   = hit_ff;
         rsp_ev_in    = !hit_ff && full;
         rsp_evb_in   = (!hit_ff && full) ? mfsc_pkg::slot_base(new_k) : '0;
         rsp_rem_in   = '0;
      end

      if (cmd.rel_step) begin
         // Close the gap left by the first entry of the window.
         for (int i = 0; i < E - 1; i++) begin
            if (mfsc_pkg::IDX_W'(i) >= win_pos) begin
               slot_key_in[i] = slot_key_ff[i+1];
               slot_k_in[i]   = slot_k_ff[i+1];
            end
         end
         count_in = count_ff - mfsc_pkg::CNT_W'(1);
         if (removed_ff != '1) begin
            removed_in = removed_ff + mfsc_pkg::REMOVED_W'(1);
         end
      end

      if (cmd.rel_finish) begin
         rsp_valid_in = 1'b1;
         rsp_base_in  = '0;
         rsp_hit_in   = 1'b0;
         rsp_ev_in    = 1'b0;
         rsp_evb_in   = '0;
         rsp_rem_in   = removed_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      key_ff     <= key_in;
      hit_ff     <= hit_in;
      pos_ff     <= pos_in;
      free_k_ff  <= free_k_in;
      removed_ff <= removed_in;
      rsp_base_ff <= rsp_base_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_ev_ff   <= rsp_ev_in;
      rsp_evb_ff  <= rsp_evb_in;
      rsp_rem_ff  <= rsp_rem_in;
      for (int i = 0; i < E; i++) begin
         slot_key_ff[i] <= slot_key_in[i];
         slot_k_ff[i]   <= slot_k_in[i];
      end
   end

   assign status.is_release = (op_ff == mfsc_pkg::OP_RELEASE);
   assign status.win_found  = any_win;
   assign status.out_free   = out_free;
   assign status.count      = count_ff;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_list_base     = rsp_base_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_evicted       = rsp_ev_ff;
   assign rsp_evicted_base  = rsp_evb_ff;
   assign rsp_removed_count = rsp_rem_ff;

endmodule

>>> hw/rtl/mru_font_slot_cache_top.sv
// A lookup passes through the capture, search and update steps of the
// controller, and its result is registered in the response register, the
// update step waiting while that register is full. A release holds the block
// for its removal loop, which takes out one matching entry at a time. Reset
// (synchronous, active high) empties the cache and the response register at
// once; the slot contents need no clearing pass.
// ----------------------------------------------------------------------------
// Move-to-front font slot cache
// Holds up to ENTRIES font slots in recency order. A lookup that hits moves
// its slot to the front, a miss allocates a free base or evicts the least
// recently used slot, and a release drops every slot of one window.
// ----------------------------------------------------------------------------
module mru_font_slot_cache_top (
   input  logic          clock,
   input  logic          reset,
   mfsc_req_if.sink      req_chan,
   mfsc_rsp_if.source    rsp_chan
);

   // Commands and status run only between the controller and the datapath.
   mfsc_pkg::cmd_type    cmd;
   mfsc_pkg::status_type status;

   // The controller takes a request beat only when idle. The request is held
   // in the datapath, so a finished result may still wait in the response
   // register while the next beat is taken; the update step then stalls until
   // the response register is free.
   mfsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath keeps each slot as a key and a slot number k, whose base is
   // 1000 + 260 * k. Free slot search is then a small used mask over k.
   mfsc_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_op            (req_chan.op),
      .req_window_id     (req_chan.window_id),
      .req_italic        (req_chan.italic),
      .req_bold          (req_chan.bold),
      .req_font_size     (req_chan.font_size),
      .req_font_family   (req_chan.font_family),
      .rsp_ready         (rsp_chan.ready),
      .rsp_valid         (rsp_chan.valid),
      .rsp_list_base     (rsp_chan.list_base),
      .rsp_hit           (rsp_chan.hit),
      .rsp_evicted       (rsp_chan.evicted),
      .rsp_evicted_base  (rsp_chan.evicted_base),
      .rsp_removed_count (rsp_chan.removed_count)
   );

   // The number of held slots never exceeds the cache size.
   assert property (@(posedge clock) disable iff (reset)
      status.count <= mfsc_pkg::CNT_W'(mfsc_pkg::ENTRIES))
      else $error("slot count above cache size");

   // A hit neither evicts nor removes anything.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.hit |->
         !rsp_chan.evicted && (rsp_chan.evicted_base == '0) &&
         (rsp_chan.removed_count == '0))
      else $error("hit result carries eviction or removal");

   // In the cycle after a request beat is taken, the block is not ready.
   assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("request taken while previous one in progress");

   // A slot is only evicted when the cache was full.
   assert property (@(posedge clock) disable iff (reset)
      cmd.apply && !status.is_release && (status.count != mfsc_pkg::CNT_W'(mfsc_pkg::ENTRIES))
      |=> !rsp_chan.evicted)
      else $error("eviction from a cache that was not full");

endmodule

>>> tb/sv/mfsc_checker.sv
// ----------------------------------------------------------------------------
// Font slot cache checker
// Watches the request and response channels of the font slot cache and keeps
// its own copy of the slot list in recency order. For every accepted request
// beat it works out the response and queues it. Every response beat is then
// compared with the oldest queued response.
// ----------------------------------------------------------------------------
module mfsc_checker (
   input  logic        clock,
   input  logic        reset,
   mfsc_req_if         req_mon,
   mfsc_rsp_if         rsp_mon,
   output int unsigned mismatch_count,
   output int unsigned results_due
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ENTRIES   = mfsc_pkg::ENTRIES;
   localparam int KEY_W     = mfsc_pkg::KEY_W;
   localparam int WIN_W     = mfsc_pkg::WIN_W;
   localparam int BASE_W    = mfsc_pkg::BASE_W;
   localparam int REMOVED_W = mfsc_pkg::REMOVED_W;

   typedef struct packed {
      logic [BASE_W-1:0]    list_base;
      logic                 hit;
      logic                 evicted;
      logic [BASE_W-1:0]    evicted_base;
      logic [REMOVED_W-1:0] removed_count;
   } font_result_t;

   // Slot 0 is the most recently used one.
   logic [KEY_W-1:0]  held_keys  [ENTRIES];
   logic [BASE_W-1:0] held_bases [ENTRIES];
   int unsigned       held_count;
   font_result_t      due_results_q[$];

   initial begin
      mismatch_count = 0;
      results_due    = 0;
      held_count     = 0;
   end

   function automatic void bring_to_front(input int unsigned pos,
                                          input logic [KEY_W-1:0] key,
                                          input logic [BASE_W-1:0] base);
      for (int i = int'(pos); i > 0; i--) begin
         held_keys[i]  = held_keys[i-1];
         held_bases[i] = held_bases[i-1];
      end
      held_keys[0]  = key;
      held_bases[0] = base;
   endfunction

   function automatic font_result_t resolve_font_request(input logic op,
                                                         input logic [WIN_W-1:0] win,
                                                         input logic [KEY_W-1:0] key);
      font_result_t res;
      int unsigned  kept;
      int unsigned  removed;
      int unsigned  pos;
      logic         found;
      logic         picked;
      logic         taken;
      logic [31:0]  cand;
      res = '0;
      if (op == mfsc_pkg::OP_RELEASE) begin
         kept    = 0;
         removed = 0;
         for (int i = 0; i < int'(held_count); i++) begin
            if (held_keys[i][KEY_W-1 -: WIN_W] == win) begin
               removed++;
            end else begin
               held_keys[kept]  = held_keys[i];
               held_bases[kept] = held_bases[i];
               kept++;
            end
         end
         held_count        = kept;
         res.removed_count = (removed > 15) ? 4'd15 : removed[REMOVED_W-1:0];
      end else begin
         found = 1'b0;
         pos   = 0;
         for (int i = 0; i < int'(held_count); i++) begin
            if (!found && held_keys[i] == key) begin
               found = 1'b1;
               pos   = i;
            end
         end
         if (found) begin
            res.hit       = 1'b1;
            res.list_base = held_bases[pos];
            bring_to_front(pos, key, res.list_base);
         end else if (held_count == ENTRIES) begin
            res.evicted      = 1'b1;
            res.evicted_base = held_bases[ENTRIES-1];
            res.list_base    = res.evicted_base;
            bring_to_front(ENTRIES - 1, key, res.list_base);
         end else begin
            // Smallest base 1000 + 260 * k, k from 1, that no held slot uses.
            cand          = mfsc_pkg::BASE_START + mfsc_pkg::BASE_STEP;
            res.list_base = cand[BASE_W-1:0];
            picked        = 1'b0;
            for (int k = 1; k <= ENTRIES + 1; k++) begin
               cand  = mfsc_pkg::BASE_START + mfsc_pkg::BASE_STEP * k;
               taken = 1'b0;
               for (int i = 0; i < int'(held_count); i++) begin
                  if (held_bases[i] == cand[BASE_W-1:0]) taken = 1'b1;
               end
               if (!picked && !taken) begin
                  res.list_base = cand[BASE_W-1:0];
                  picked        = 1'b1;
               end
            end
            bring_to_front(held_count, key, res.list_base);
            held_count++;
         end
      end
      return res;
   endfunction

   task automatic note_mismatch(input string what, input font_result_t want,
                                input font_result_t got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t: %s: expected base %0d hit %0d evicted %0d/%0d removed %0d,",
                  $realtime, what, want.list_base, want.hit, want.evicted,
                  want.evicted_base, want.removed_count);
         $display("   got base %0d hit %0d evicted %0d/%0d removed %0d",
                  got.list_base, got.hit, got.evicted, got.evicted_base,
                  got.removed_count);
      end
   endtask

   always @(posedge clock) begin : watch_channels
      font_result_t got;
      font_result_t want;
      if (reset) begin
         held_count = 0;
         due_results_q.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{list_base:     rsp_mon.list_base,
                    hit:           rsp_mon.hit,
                    evicted:       rsp_mon.evicted,
                    evicted_base:  rsp_mon.evicted_base,
                    removed_count: rsp_mon.removed_count};
            if (due_results_q.size() == 0) begin
               note_mismatch("response beat with nothing outstanding", '0, got);
            end else begin
               want = due_results_q.pop_front();
               if (got !== want) note_mismatch("response mismatch", want, got);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            due_results_q.push_back(resolve_font_request(
               req_mon.op, req_mon.window_id,
               {req_mon.window_id, req_mon.italic, req_mon.bold,
                req_mon.font_size, req_mon.font_family}));
         end
      end
      results_due = due_results_q.size();
   end

endmodule

>>> tb/sv/tb_mru_font_slot_cache_top.sv
// ----------------------------------------------------------------------------
// Font slot cache testbench
// Drives lookup and release beats into the move-to-front font slot cache,
// first a short directed sequence and then a long random one built around a
// few windows and recently used keys so that hits, evictions and releases of
// neighbouring slots are all common. Both channel ends idle at random. The
// checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_mru_font_slot_cache_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int RANDOM_BEATS    = 450;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 24;

   logic        clock;
   logic        reset;
   int unsigned mismatch_count;
   int unsigned results_due;

   // Set by the stimulus: no_idle removes every gap on both sides, and
   // want_hold_off asks the receiver for one long stall.
   logic        no_idle       = 1'b0;
   logic        want_hold_off = 1'b0;

   mfsc_req_if req_bus ();
   mfsc_rsp_if rsp_bus ();

   mru_font_slot_cache_top u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   mfsc_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .mismatch_count (mismatch_count),
      .results_due    (results_due)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Watchdog: a hung handshake must not keep the run going for ever.
   initial begin : watchdog
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   // Receiver. Each falling edge makes exactly one assignment to ready. Most
   // cycles accept, short stalls are common and long ones rare. The long
   // hold-off is counted here so that the sender carries on offering beats
   // and the block backs up into its request channel.
   initial begin : receiver
      int unsigned stall_left;
      int unsigned roll;
      stall_left    = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (want_hold_off) begin
            want_hold_off = 1'b0;
            stall_left    = HOLD_OFF_CYCLES;
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (no_idle) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
               rsp_bus.ready <= 1'b1;
            end else begin
               rsp_bus.ready <= 1'b0;
               stall_left = (roll < 96) ? $urandom_range(0, 3) : $urandom_range(20, 60);
            end
         end
      end
   end

   // Offers one request beat after a random gap and returns once it has been
   // accepted. With no gap, valid simply stays high into the next beat.
   task automatic offer_font_req(input logic op, input logic [7:0] win,
                                 input logic ital, input logic bld,
                                 input logic [7:0] size, input logic [1:0] fam);
      int unsigned gap;
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (no_idle || roll < 60) begin
         gap = 0;
      end else if (roll < 95) begin
         gap = $urandom_range(1, 3);
      end else begin
         gap = $urandom_range(20, 60);
      end
      if (gap > 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid       <= 1'b1;
      req_bus.op          <= op;
      req_bus.window_id   <= win;
      req_bus.italic      <= ital;
      req_bus.bold        <= bld;
      req_bus.font_size   <= size;
      req_bus.font_family <= fam;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
   endtask

   initial begin : stimulus
      logic [7:0]  win_pool [4];
      logic [19:0] recent_keys_q[$];
      logic [19:0] key;
      int unsigned roll;

      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.op          = mfsc_pkg::OP_LOOKUP;
      req_bus.window_id   = '0;
      req_bus.italic      = 1'b0;
      req_bus.bold        = 1'b0;
      req_bus.font_size   = '0;
      req_bus.font_family = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. A first miss allocates the lowest base and a repeat
      // of the same key hits. The all-ones key checks the top of every field.
      offer_font_req(mfsc_pkg::OP_LOOKUP, 8'd0, 1'b0, 1'b0, 8'd0, 2'd0);
      offer_font_req(mfsc_pkg::OP_LOOKUP, 8'd0, 1'b0, 1'b0, 8'd0, 2'd0);
      offer_font_req(mfsc_pkg::OP_LOOKUP, 8'd255, 1'b1, 1'b1, 8'd255, 2'd3);
      // Releasing a window that holds nothing changes nothing; the style,
      // size and family fields of a release are ignored.
      offer_font_req(mfsc_pkg::OP_RELEASE, 8'd7, 1'b1, 1'b1, 8'd255, 2'd3);
      // Fill the cache with one window's fonts so that it is full.
      for (int s = 1; s <= 8; s++) begin
         offer_font_req(mfsc_pkg::OP_LOOKUP, 8'd1, s[0], s[1], 8'(s), s[1:0]);
      end
      // Misses on a full cache evict the least recently used slot.
      offer_font_req(mfsc_pkg::OP_LOOKUP, 8'd2, 1'b0, 1'b1, 8'd9, 2'd1);
      offer_font_req(mfsc_pkg::OP_LOOKUP, 8'd0, 1'b0, 1'b0, 8'd0, 2'd0);
      // A hit in the middle of the list moves that slot to the front.
      offer_font_req(mfsc_pkg::OP_LOOKUP, 8'd1, 1'b0, 1'b0, 8'd4, 2'd0);
      // Releasing window 1 removes a run of neighbouring slots.
      offer_font_req(mfsc_pkg::OP_RELEASE, 8'd1, 1'b0, 1'b0, 8'd0, 2'd0);
      // The next miss reuses the smallest base freed by the release.
      offer_font_req(mfsc_pkg::OP_LOOKUP, 8'd3, 1'b1, 1'b0, 8'd5, 2'd2);
      offer_font_req(mfsc_pkg::OP_RELEASE, 8'd255, 1'b1, 1'b1, 8'd255, 2'd3);
      offer_font_req(mfsc_pkg::OP_RELEASE, 8'd0, 1'b0, 1'b1, 8'd17, 2'd1);
      offer_font_req(mfsc_pkg::OP_RELEASE, 8'd2, 1'b1, 1'b0, 8'd0, 2'd2);
      offer_font_req(mfsc_pkg::OP_RELEASE, 8'd3, 1'b0, 1'b0, 8'd0, 2'd0);
      // Release on an empty cache.
      offer_font_req(mfsc_pkg::OP_RELEASE, 8'd3, 1'b0, 1'b0, 8'd0, 2'd0);

      // Random part. Most keys come from a handful of windows and small sizes,
      // and many repeat a recent key, so that the cache fills, hits, evicts
      // and loses whole windows at a time.
      win_pool[0] = 8'd0;
      win_pool[1] = 8'd255;
      win_pool[2] = 8'($urandom);
      win_pool[3] = 8'($urandom);
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (n == 150) begin
            want_hold_off = 1'b1;
         end
         if (n == 300) begin
            // Let the block drain completely before going on.
            @(negedge clock);
            req_bus.valid <= 1'b0;
            while (results_due != 0) @(negedge clock);
         end
         no_idle = (n >= 330 && n < 400);
         if ($urandom_range(0, 49) == 0) begin
            win_pool[$urandom_range(2, 3)] = 8'($urandom);
         end

         roll = $urandom_range(0, 99);
         if (roll < 12) begin
            key        = 20'($urandom);
            key[19:12] = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                      : win_pool[$urandom_range(0, 3)];
            offer_font_req(mfsc_pkg::OP_RELEASE, key[19:12], key[11], key[10],
                           key[9:2], key[1:0]);
         end else begin
            if (roll < 50 && recent_keys_q.size() > 0) begin
               key = recent_keys_q[$urandom_range(0, recent_keys_q.size() - 1)];
            end else if (roll < 90) begin
               key[19:12] = win_pool[$urandom_range(0, 3)];
               key[11:10] = 2'($urandom);
               key[9:2]   = ($urandom_range(0, 6) == 6) ? 8'd255 : 8'($urandom_range(0, 5));
               key[1:0]   = 2'($urandom);
            end else begin
               key = 20'($urandom);
            end
            recent_keys_q.push_back(key);
            if (recent_keys_q.size() > 16) void'(recent_keys_q.pop_front());
            offer_font_req(mfsc_pkg::OP_LOOKUP, key[19:12], key[11], key[10],
                           key[9:2], key[1:0]);
         end
      end
      no_idle = 1'b0;

      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (results_due != 0) @(negedge clock);
      // Keep running so that any surplus response beat is seen.
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatch_count == 0 && results_due == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/mfsc_pkg.sv
hw/rtl/mfsc_req_if.sv
hw/rtl/mfsc_rsp_if.sv
hw/rtl/mfsc_ctrl.sv
hw/rtl/mfsc_datapath.sv
hw/rtl/mru_font_slot_cache_top.sv
tb/sv/mfsc_checker.sv
tb/sv/tb_mru_font_slot_cache_top.sv
